// ===== rtl/core/rmmwm_pkg.sv =====
// Shared types and constants for the running minimum, maximum and window mean core.
// Depends on nothing; used by the divider, the top level and the testbench.
package rmmwm_pkg;

    localparam int DATA_W = 16;

    localparam logic signed [DATA_W-1:0] MIN_RESET = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] MAX_RESET = 16'sh8000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/rmmwm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module rmmwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rmmwm_div.sv =====
// Bit-serial restoring divider: signed dividend by unsigned count, one quotient bit a cycle.
// Depends on rmmwm_pkg for the result width.
module rmmwm_div #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [SUM_W-1:0]          i_dividend,
    input  logic [CNT_W-1:0]                 i_divisor,
    output logic                             o_done,
    output logic signed [rmmwm_pkg::DATA_W-1:0] o_quotient
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W:0]   r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_divisor;
    logic             r_neg;

    logic [CNT_W:0]   rem_sh;
    logic             fits;
    logic [CNT_W:0]   n_rem;
    logic [SUM_W-1:0] n_quo;
    logic [SUM_W-1:0] magnitude;
    logic [SUM_W-1:0] signed_quo;

    always_comb begin
        magnitude = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
        rem_sh    = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
        fits      = rem_sh >= {1'b0, r_divisor};
        n_rem     = fits ? (rem_sh - {1'b0, r_divisor}) : rem_sh;
        n_quo     = {r_quo[SUM_W-2:0], fits};
        signed_quo = r_neg ? (~r_quo + 1'b1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= magnitude;
            r_divisor <= i_divisor;
            r_neg     <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = signed_quo[rmmwm_pkg::DATA_W-1:0];

endmodule

// ===== rtl/core/running_min_max_window_mean_core.sv =====
// Running minimum, maximum and window mean of a signed 16-bit sample stream.
// A taken sample is registered, then passes through states S_SUM, S_DIV and S_DONE; in
// S_DIV the bit-serial divider forms SUM_W (16 plus clog2(WINDOW)) quotient bits.
// One item is processed at a time, so no new transaction is taken until S_DONE has moved
// its result to the output register; the next is taken while the result waits there.
// Synchronous active-low reset presets extremes; clears sum, fill count and ring position.
module running_min_max_window_mean_core #(
    parameter int WINDOW = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [rmmwm_pkg::DATA_W-1:0]   i_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rmmwm_pkg::DATA_W-1:0]   o_min_value,
    output logic signed [rmmwm_pkg::DATA_W-1:0]   o_max_value,
    output logic signed [rmmwm_pkg::DATA_W-1:0]   o_mean_value
);

    localparam int DW    = rmmwm_pkg::DATA_W;
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = DW + $clog2(WINDOW);

    rmmwm_pkg::t_state r_state, n_state;

    logic signed [DW-1:0]    r_sample;
    logic signed [DW-1:0]    r_min, n_min;
    logic signed [DW-1:0]    r_max, n_max;
    logic [IDX_W-1:0]        r_slot, n_slot;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                    r_out_valid;
    logic signed [DW-1:0]    r_out_min, r_out_max, r_out_mean;

    logic                    in_take;
    logic                    out_load;
    logic                    ram_we;
    logic                    div_start;
    logic                    div_done;
    logic signed [DW-1:0]    div_quo;
    logic [DW-1:0]           old_sample;
    logic                    full;

    rmmwm_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (old_sample)
    );

    rmmwm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            rmmwm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = rmmwm_pkg::S_SUM;
                end
            end
            rmmwm_pkg::S_SUM: begin
                n_state = rmmwm_pkg::S_DIV;
            end
            rmmwm_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = rmmwm_pkg::S_DONE;
                end
            end
            rmmwm_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = rmmwm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmmwm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            rmmwm_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            rmmwm_pkg::S_SUM: begin
                ram_we    = 1'b1;
                div_start = 1'b1;
            end
            rmmwm_pkg::S_DIV: begin
            end
            rmmwm_pkg::S_DONE: begin
                out_load = !r_out_valid || i_ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        in_take = i_valid && o_ready;
        full    = r_fill >= CNT_W'(WINDOW);
        n_min   = (in_take && (i_sample < r_min)) ? i_sample : r_min;
        n_max   = (in_take && (i_sample > r_max)) ? i_sample : r_max;
        n_sum   = r_sum + SUM_W'(r_sample);
        if (full) begin
            n_sum = n_sum - SUM_W'($signed(old_sample));
        end
        n_fill = full ? r_fill : r_fill + 1'b1;
        n_slot = (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmmwm_pkg::S_IDLE;
            r_min       <= rmmwm_pkg::MIN_RESET;
            r_max       <= rmmwm_pkg::MAX_RESET;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_min   <= n_min;
            r_max   <= n_max;
            if (ram_we) begin
                r_slot <= n_slot;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_sample;
        end
        if (out_load) begin
            r_out_min  <= r_min;
            r_out_max  <= r_max;
            r_out_mean <= div_quo;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_min_value  = r_out_min;
    assign o_max_value  = r_out_max;
    assign o_mean_value = r_out_mean;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for running_min_max_window_mean_core.
// Depends on rmmwm_pkg and the core. It runs a directed stimulus table and then random sample bursts,
// and checks each result against a predictor of the running extremes and window mean or a typed row.
module tb;

    localparam int W = rmmwm_pkg::DATA_W;
    localparam int WINDOW = 10;
    localparam int RANDOM_ITEMS = 1025;
    localparam int STALL_LIMIT = 2000;
    localparam logic signed [W-1:0] SMAX = 16'sh7FFF;
    localparam logic signed [W-1:0] SMIN = 16'sh8000;

    typedef struct packed {
        logic signed [W-1:0] min_value;
        logic signed [W-1:0] max_value;
        logic signed [W-1:0] mean_value;
    } stats_t;

    typedef struct packed {
        logic signed [W-1:0] sample;
        logic                typed;
        stats_t              want;
    } row_t;

    localparam stats_t NONE = '0;

    localparam row_t PLAN [25] = '{
        '{16'sd0,      1'b1, '{16'sd0, 16'sd0, 16'sd0}},
        '{-16'sd1,     1'b1, '{-16'sd1, 16'sd0, 16'sd0}},
        '{16'sd1,      1'b0, NONE},
        '{16'sd21845,  1'b0, NONE},
        '{-16'sd21846, 1'b0, NONE},
        '{SMAX,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b0, NONE},
        '{SMIN,        1'b1, '{SMIN, SMAX, SMIN}},
        '{SMAX,        1'b0, NONE},
        '{SMAX,        1'b0, NONE},
        '{SMAX,        1'b0, NONE},
        '{SMAX,        1'b0, NONE},
        '{SMAX,        1'b0, NONE},
        '{SMAX,        1'b0, NONE},
        '{SMAX,        1'b0, NONE},
        '{SMAX,        1'b0, NONE}
    };

    logic                clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic signed [W-1:0] i_sample = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [W-1:0] o_min_value;
    logic signed [W-1:0] o_max_value;
    logic signed [W-1:0] o_mean_value;

    logic signed [W-1:0] lowest;
    logic signed [W-1:0] highest;
    logic signed [W-1:0] ring [WINDOW];
    int                  ring_slot;
    int                  ring_fill;
    int                  ring_sum;

    stats_t              stats_due [$];
    int                  mismatch_count = 0;
    int                  samples_taken = 0;
    int                  stall_cycles = 0;
    logic                calm;

    assign calm = (samples_taken >= 400) && (samples_taken < 650);

    running_min_max_window_mean_core #(
        .WINDOW(WINDOW)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_min_value (o_min_value),
        .o_max_value (o_max_value),
        .o_mean_value(o_mean_value)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic stats_t step_window_stats(logic signed [W-1:0] s);
        stats_t r;
        if (s < lowest) lowest = s;
        if (s > highest) highest = s;
        if (ring_fill < WINDOW) begin
            ring_sum += int'(s);
            ring_fill++;
        end else begin
            ring_sum += int'(s) - int'(ring[ring_slot]);
        end
        ring[ring_slot] = s;
        ring_slot = (ring_slot + 1) % WINDOW;
        r.min_value = lowest;
        r.max_value = highest;
        r.mean_value = W'(ring_sum / ring_fill);
        return r;
    endfunction

    task automatic send_sample(input logic signed [W-1:0] s);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 8) begin
            i_valid = 1'b0;
            @(negedge clk);
        end
        i_valid = 1'b1;
        i_sample = s;
        do @(posedge clk); while (!o_ready);
        samples_taken++;
    endtask

    always @(negedge clk) begin
        i_ready = calm || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge clk) begin : check_results
        stats_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (stats_due.size() == 0) begin
                $display("%0t: unexpected result min %0d max %0d mean %0d", $time,
                         o_min_value, o_max_value, o_mean_value);
                mismatch_count++;
            end else begin
                want = stats_due.pop_front();
                if (o_min_value !== want.min_value) begin
                    $display("%0t: min_value expected %0d got %0d", $time,
                             want.min_value, o_min_value);
                    mismatch_count++;
                end
                if (o_max_value !== want.max_value) begin
                    $display("%0t: max_value expected %0d got %0d", $time,
                             want.max_value, o_max_value);
                    mismatch_count++;
                end
                if (o_mean_value !== want.mean_value) begin
                    $display("%0t: mean_value expected %0d got %0d", $time,
                             want.mean_value, o_mean_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        stats_t              st;
        logic signed [W-1:0] s;
        logic signed [W-1:0] level;
        int                  sent;
        int                  burst;
        int                  mode;

        lowest = SMAX;
        highest = SMIN;
        ring_slot = 0;
        ring_fill = 0;
        ring_sum = 0;
        foreach (ring[k]) ring[k] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        i_rst_n = 1'b1;

        foreach (PLAN[k]) begin
            send_sample(PLAN[k].sample);
            st = step_window_stats(PLAN[k].sample);
            stats_due.push_back(PLAN[k].typed ? PLAN[k].want : st);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 20);
            mode = $urandom_range(0, 5);
            level = $urandom_range(0, 1) ? SMAX : SMIN;
            repeat (burst) begin
                case (mode)
                    0: s = level;
                    1: s = W'(int'($urandom_range(0, 200)) - 100);
                    5: s = level[W-1] ? level + W'($urandom_range(0, 15))
                                      : level - W'($urandom_range(0, 15));
                    default: s = W'($urandom_range(0, 65535));
                endcase
                send_sample(s);
                st = step_window_stats(s);
                stats_due.push_back(st);
                sent++;
            end
        end

        @(negedge clk);
        i_valid = 1'b0;

        while (stats_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
